FILE: sv/shs_pkg.sv
// shared types and constants for the stepper homing sequencer
`default_nettype none
package shs_pkg;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_STEP  = 2'd2;

   localparam logic [1:0] CSR_ACTIVE_LEVEL    = 2'd0;
   localparam logic [1:0] CSR_DWELL_US        = 2'd1;
   localparam logic [1:0] CSR_BACKOFF_STEPS   = 2'd2;
   localparam logic [1:0] CSR_TIMEOUT_SECONDS = 2'd3;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   // (255 + 1) * 1000000 still fits in 28 bits
   localparam int THRESH_WIDTH = 29;
   localparam logic [THRESH_WIDTH-1:0] US_PER_SECOND = THRESH_WIDTH'(1000000);

   localparam logic        RST_ACTIVE_LEVEL  = 1'b1;
   localparam logic [15:0] RST_DWELL_US      = 16'd1000;
   localparam logic [15:0] RST_BACKOFF_STEPS = 16'd0;
   localparam logic [7:0]  RST_TIMEOUT_SEC   = 8'd10;

   typedef struct packed {
      logic [1:0] operation;
      logic       direction;
      logic       switch_level;
   } item_type;

   typedef struct packed {
      logic                    active_level;
      logic [15:0]             dwell_us;
      logic [15:0]             backoff_steps;
      logic [THRESH_WIDTH-1:0] threshold;
   } cfg_type;

   typedef struct packed {
      logic step_pulse;
      logic dir_level;
      logic enable_level;
      logic at_endstop;
      logic busy_res;
      logic timeout_fault;
   } result_type;

   // elapsed time limit that ends a seek: elapsed / 1e6 > t  <=>  elapsed >= (t + 1) * 1e6
   function automatic logic [THRESH_WIDTH-1:0] seek_limit(input logic [7:0] seconds);
      logic [THRESH_WIDTH-1:0] whole;
      whole = THRESH_WIDTH'(seconds) + THRESH_WIDTH'(1);
      return THRESH_WIDTH'(whole * US_PER_SECOND);
   endfunction

endpackage
`default_nettype wire

FILE: sv/stepper_homing_sequencer.sv
// top level of the stepper homing sequencer: handshakes, settings and result register
// a request transaction passes the input register, then the result register, before its
// response is valid; throughput: one transaction per cycle while the response side
// does not stall; the homing state updates in a single pass
// the result register takes a new transaction while the old one is being taken
// reset (synchronous, active high): idle, driver disabled, fault clear, elapsed time zero
// settings return to active level 1, dwell 1000 us, no back-off, 10 s timeout
`default_nettype none
module stepper_homing_sequencer #(
   parameter int ELAPSED_WIDTH = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // request channel
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [1:0]                            req_operation,
   input  wire logic                                  req_direction,
   input  wire logic                                  req_switch_level,
   // response channel
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic                                       rsp_step_pulse,
   output logic                                       rsp_dir_level,
   output logic                                       rsp_enable_level,
   output logic                                       rsp_at_endstop,
   output logic                                       rsp_busy_res,
   output logic                                       rsp_timeout_fault,
   // settings write channel
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [shs_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [shs_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);
   import shs_pkg::*;

   // settings registers; the timeout is kept as its microsecond limit
   logic                    active_level_ff, active_level_in;
   logic [15:0]             dwell_ff, dwell_in;
   logic [15:0]             backoff_steps_ff, backoff_steps_in;
   logic [THRESH_WIDTH-1:0] threshold_ff, threshold_in;

   // input register
   logic       in_valid_ff, in_valid_in;
   item_type   item_ff, item_in;

   // result register
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;

   logic       req_take;
   logic       out_open;
   logic       fire;
   logic       csr_take;
   cfg_type    cfg;
   result_type core_result;

   // settings writes are always taken
   assign csr_ready = 1'b1;
   assign csr_take  = csr_valid & csr_ready;

   always_comb begin
      active_level_in  = active_level_ff;
      dwell_in         = dwell_ff;
      backoff_steps_in = backoff_steps_ff;
      threshold_in     = threshold_ff;
      if (csr_take) begin
         case (csr_index)
            CSR_ACTIVE_LEVEL:    active_level_in  = csr_wdata[0];
            CSR_DWELL_US:        dwell_in         = csr_wdata[15:0];
            CSR_BACKOFF_STEPS:   backoff_steps_in = csr_wdata[15:0];
            CSR_TIMEOUT_SECONDS: threshold_in     = seek_limit(csr_wdata[7:0]);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_level_ff  <= RST_ACTIVE_LEVEL;
         dwell_ff         <= RST_DWELL_US;
         backoff_steps_ff <= RST_BACKOFF_STEPS;
         threshold_ff     <= seek_limit(RST_TIMEOUT_SEC);
      end else begin
         active_level_ff  <= active_level_in;
         dwell_ff         <= dwell_in;
         backoff_steps_ff <= backoff_steps_in;
         threshold_ff     <= threshold_in;
      end
   end

   assign cfg.active_level  = active_level_ff;
   assign cfg.dwell_us      = dwell_ff;
   assign cfg.backoff_steps = backoff_steps_ff;
   assign cfg.threshold     = threshold_ff;

   // the result register can load when empty or when its transaction leaves now
   assign out_open  = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_open;
   assign req_stall = in_valid_ff && !out_open;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      item_in.operation    = req_operation;
      item_in.direction    = req_direction;
      item_in.switch_level = req_switch_level;

      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (fire) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
      out_in = core_result;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
      if (fire) begin
         out_ff <= out_in;
      end
   end

   // homing state and next-state logic
   shs_core #(
      .ELAPSED_WIDTH(ELAPSED_WIDTH)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .item  (item_ff),
      .cfg   (cfg),
      .result(core_result)
   );

   assign rsp_valid         = out_valid_ff;
   assign rsp_step_pulse    = out_ff.step_pulse;
   assign rsp_dir_level     = out_ff.dir_level;
   assign rsp_enable_level  = out_ff.enable_level;
   assign rsp_at_endstop    = out_ff.at_endstop;
   assign rsp_busy_res      = out_ff.busy_res;
   assign rsp_timeout_fault = out_ff.timeout_fault;

   // a step is only ever issued with the driver enabled
   a_step_enabled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_step_pulse |-> !rsp_enable_level)
      else $error("step pulse with driver disabled");

   // a timeout can only come out of a seek, which enables the driver
   a_fault_enabled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_timeout_fault |-> !rsp_enable_level)
      else $error("timeout fault with driver disabled");

   // requests are held back only when both registers are full and the output is stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff && rsp_stall)
      else $error("request stalled without a full pipeline");

   // a transaction that moved into the result register is shown the next cycle
   a_fire_shows: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid)
      else $error("result register did not load");

endmodule
`default_nettype wire

FILE: sv/shs_core.sv
// homing state machine: seek, back-off and single step, one transaction per fire
`default_nettype none
module shs_core #(
   parameter int ELAPSED_WIDTH = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                fire,
   input  wire shs_pkg::item_type   item,
   input  wire shs_pkg::cfg_type    cfg,
   output shs_pkg::result_type      result
);
   import shs_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_SEEK    = 2'd1,
      PH_BACKOFF = 2'd2
   } phase_type;

   localparam int CMP_WIDTH = (ELAPSED_WIDTH > THRESH_WIDTH) ? ELAPSED_WIDTH : THRESH_WIDTH;

   phase_type                phase_ff, phase_in;
   logic [ELAPSED_WIDTH-1:0] elapsed_ff, elapsed_in;
   logic [15:0]              backoff_count_ff, backoff_count_in;
   logic                     seek_dir_ff, seek_dir_in;
   logic                     fault_ff, fault_in;
   logic                     enable_ff, enable_in;
   logic                     dir_ff, dir_in;

   logic                     at;
   logic                     busy;
   logic                     step;
   logic [ELAPSED_WIDTH:0]   sum;
   logic [ELAPSED_WIDTH-1:0] elapsed_sat;
   logic [15:0]              count_dec;
   logic                     timed_out;

   always_comb begin
      at          = (item.switch_level == cfg.active_level);
      busy        = (phase_ff == PH_SEEK) || (phase_ff == PH_BACKOFF);
      sum         = {1'b0, elapsed_ff} + (ELAPSED_WIDTH + 1)'(cfg.dwell_us);
      elapsed_sat = sum[ELAPSED_WIDTH] ? {ELAPSED_WIDTH{1'b1}} : sum[ELAPSED_WIDTH-1:0];
      timed_out   = CMP_WIDTH'(elapsed_sat) >= CMP_WIDTH'(cfg.threshold);
      count_dec   = backoff_count_ff - 16'd1;

      phase_in         = phase_ff;
      elapsed_in       = elapsed_ff;
      backoff_count_in = backoff_count_ff;
      seek_dir_in      = seek_dir_ff;
      fault_in         = fault_ff;
      enable_in        = enable_ff;
      dir_in           = dir_ff;
      step             = 1'b0;

      case (item.operation)
         OP_TICK: begin
            if (phase_ff == PH_SEEK) begin
               if (!at) begin
                  step       = 1'b1;
                  elapsed_in = elapsed_sat;
                  if (timed_out) begin
                     fault_in = 1'b1;
                  end
               end
               if (at || timed_out) begin
                  // reverse and load the back-off count
                  dir_in           = ~seek_dir_ff;
                  backoff_count_in = cfg.backoff_steps;
                  phase_in         = (cfg.backoff_steps != 16'd0) ? PH_BACKOFF : PH_IDLE;
               end
            end else if (phase_ff == PH_BACKOFF) begin
               if (backoff_count_ff != 16'd0) begin
                  step             = 1'b1;
                  backoff_count_in = count_dec;
               end
               if (backoff_count_ff == 16'd0 || count_dec == 16'd0) begin
                  phase_in = PH_IDLE;
               end
            end
         end
         OP_START: begin
            if (!busy) begin
               enable_in   = 1'b0;
               seek_dir_in = item.direction;
               dir_in      = item.direction;
               fault_in    = 1'b0;
               elapsed_in  = '0;
               phase_in    = PH_SEEK;
            end
         end
         OP_STEP: begin
            if (!busy) begin
               enable_in   = 1'b0;
               seek_dir_in = item.direction;
               dir_in      = item.direction;
               step        = ~at;
            end
         end
         default: begin
         end
      endcase

      result.step_pulse    = step;
      result.dir_level     = dir_in;
      result.enable_level  = enable_in;
      result.at_endstop    = at;
      result.busy_res      = (phase_in == PH_SEEK) || (phase_in == PH_BACKOFF);
      result.timeout_fault = fault_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         elapsed_ff       <= '0;
         backoff_count_ff <= 16'd0;
         seek_dir_ff      <= 1'b0;
         fault_ff         <= 1'b0;
         enable_ff        <= 1'b1;
         dir_ff           <= 1'b0;
      end else if (fire) begin
         phase_ff         <= phase_in;
         elapsed_ff       <= elapsed_in;
         backoff_count_ff <= backoff_count_in;
         seek_dir_ff      <= seek_dir_in;
         fault_ff         <= fault_in;
         enable_ff        <= enable_in;
         dir_ff           <= dir_in;
      end
   end

endmodule
`default_nettype wire

FILE: tb/tb_stepper_homing_sequencer.sv
// testbench for the stepper homing sequencer: directed table, long homing run, random homing runs
`timescale 1ns / 100ps
module tb_stepper_homing_sequencer;
   import shs_pkg::*;

   localparam int ELAPSED_W = 32;
   localparam logic [63:0] US_PER_SEC = 64'd1000000;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   // cycles without any transaction before the run is declared hung
   localparam int STUCK_LIMIT = 2000;
   // long receiver hold-off that backs the block up into its request side
   localparam int HOLD_CYCLES = 300;
   localparam int RANDOM_ITEMS = 500;
   localparam int ROUND_ITEMS = 60;

   typedef enum logic [1:0] {HOME_IDLE, HOME_SEEK, HOME_BACKOFF} home_mode_type;
   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   // one line of the directed table: either a command or a register write
   typedef struct {
      row_kind_type               kind;
      logic [1:0]                 op;
      logic                       dir;
      logic                       sw;
      bit                         typed;
      result_type                 want;
      logic [CSR_INDEX_WIDTH-1:0] idx;
      logic [CSR_DATA_WIDTH-1:0]  data;
   } plan_row_type;

   // dut ports, all inputs known from time zero
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_operation = '0;
   logic req_direction = 1'b0;
   logic req_switch_level = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_step_pulse;
   logic rsp_dir_level;
   logic rsp_enable_level;
   logic rsp_at_endstop;
   logic rsp_busy_res;
   logic rsp_timeout_fault;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   // settings as the block should hold them
   logic cfg_active = RST_ACTIVE_LEVEL;
   logic [15:0] cfg_dwell = RST_DWELL_US;
   logic [15:0] cfg_backoff = RST_BACKOFF_STEPS;
   logic [7:0] cfg_timeout = RST_TIMEOUT_SEC;

   // homing state as the block should hold it
   home_mode_type mode = HOME_IDLE;
   logic [ELAPSED_W-1:0] elapsed = '0;
   logic [15:0] backoff_left = '0;
   logic seek_dir = 1'b0;
   logic fault = 1'b0;
   logic enable_pin = 1'b1;
   logic at_flag = 1'b0;
   logic dir_pin = 1'b0;

   result_type expected_pins[$];
   plan_row_type plan[$];
   int mismatch_count = 0;
   int items_sent = 0;
   int stuck_cycles = 0;
   int hold_left = 0;
   bit calm = 1'b0;
   bit hold_req = 1'b0;

   stepper_homing_sequencer dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_direction     (req_direction),
      .req_switch_level  (req_switch_level),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_step_pulse    (rsp_step_pulse),
      .rsp_dir_level     (rsp_dir_level),
      .rsp_enable_level  (rsp_enable_level),
      .rsp_at_endstop    (rsp_at_endstop),
      .rsp_busy_res      (rsp_busy_res),
      .rsp_timeout_fault (rsp_timeout_fault),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // 4 ns clock
   initial begin
      forever #2 clock = ~clock;
   end

   // seek over: flip the direction pin and load the back-off count
   function automatic void enter_backoff();
      dir_pin = ~seek_dir;
      backoff_left = cfg_backoff;
      mode = (backoff_left != 0) ? HOME_BACKOFF : HOME_IDLE;
   endfunction

   // advance the homing state by one command and return the pin levels it leaves
   function automatic result_type predict_pins(input logic [1:0] op, input logic dir,
                                               input logic sw);
      result_type r;
      logic busy;
      logic hit;
      logic [ELAPSED_W:0] sum;
      r = '0;
      busy = (mode != HOME_IDLE);
      hit = (sw == cfg_active);
      at_flag = hit;
      case (op)
         OP_TICK: begin
            if (mode == HOME_SEEK) begin
               if (hit) begin
                  enter_backoff();
               end else begin
                  r.step_pulse = 1'b1;
                  sum = {1'b0, elapsed} + (ELAPSED_W + 1)'(cfg_dwell);
                  // elapsed time sticks at all ones instead of wrapping
                  elapsed = sum[ELAPSED_W] ? '1 : sum[ELAPSED_W-1:0];
                  if (64'(elapsed) / US_PER_SEC > 64'(cfg_timeout)) begin
                     fault = 1'b1;
                     enter_backoff();
                  end
               end
            end else if (mode == HOME_BACKOFF) begin
               if (backoff_left != 0) begin
                  r.step_pulse = 1'b1;
                  backoff_left = backoff_left - 16'd1;
               end
               if (backoff_left == 0) mode = HOME_IDLE;
            end
         end
         OP_START: begin
            if (!busy) begin
               enable_pin = 1'b0;
               seek_dir = dir;
               dir_pin = dir;
               fault = 1'b0;
               elapsed = '0;
               mode = HOME_SEEK;
            end
         end
         OP_STEP: begin
            if (!busy) begin
               enable_pin = 1'b0;
               seek_dir = dir;
               dir_pin = dir;
               r.step_pulse = ~hit;
            end
         end
         default: ;
      endcase
      r.dir_level = dir_pin;
      r.enable_level = enable_pin;
      r.at_endstop = at_flag;
      r.busy_res = (mode != HOME_IDLE);
      r.timeout_fault = fault;
      return r;
   endfunction

   function automatic void plan_item(input logic [1:0] op, input logic dir, input logic sw,
                                     input bit typed = 1'b0, input result_type want = '0);
      plan_row_type row;
      row = '{kind: ROW_ITEM, op: op, dir: dir, sw: sw, typed: typed, want: want,
              idx: '0, data: '0};
      plan.push_back(row);
   endfunction

   function automatic void plan_csr(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                    input logic [CSR_DATA_WIDTH-1:0] data);
      plan_row_type row;
      row = '{kind: ROW_CSR, op: OP_TICK, dir: 1'b0, sw: 1'b0, typed: 1'b0, want: '0,
              idx: idx, data: data};
      plan.push_back(row);
   endfunction

   // offer one command, hold it until taken, then record what should come back
   task automatic send_command(input logic [1:0] op, input logic dir, input logic sw,
                               input bit typed = 1'b0, input result_type want = '0);
      result_type predicted;
      @(negedge clock);
      while (!calm && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_direction <= dir;
      req_switch_level <= sw;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted = predict_pins(op, dir, sw);
      expected_pins.push_back(typed ? want : predicted);
      items_sent++;
   endtask

   // leaves csr_valid high; the caller drops it once the group of writes is done
   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         CSR_ACTIVE_LEVEL:    cfg_active = data[0];
         CSR_DWELL_US:        cfg_dwell = data;
         CSR_BACKOFF_STEPS:   cfg_backoff = data;
         CSR_TIMEOUT_SECONDS: cfg_timeout = data[7:0];
         default: ;
      endcase
   endtask

   // stop offering, wait for every outstanding transaction, then let the pipeline drain
   task automatic settle_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_pins.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // all four registers; unused upper data bits carry noise that must be ignored
   task automatic apply_settings(input logic act, input logic [15:0] dwell,
                                 input logic [15:0] backoff, input logic [7:0] secs);
      settle_block();
      write_csr(CSR_ACTIVE_LEVEL, {15'($urandom), act});
      write_csr(CSR_DWELL_US, dwell);
      write_csr(CSR_BACKOFF_STEPS, backoff);
      write_csr(CSR_TIMEOUT_SECONDS, {8'($urandom), secs});
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // receiver: random stalls, a quiet round without them, and one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < 10);
         end
      end
   end

   // every response transaction is held against the oldest expectation
   always @(posedge clock) begin : rsp_check
      result_type seen;
      result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         seen = {rsp_step_pulse, rsp_dir_level, rsp_enable_level, rsp_at_endstop,
                 rsp_busy_res, rsp_timeout_fault};
         if (expected_pins.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response transaction: pins %b", seen);
         end else begin
            want = expected_pins.pop_front();
            if (seen !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"pin mismatch (expected/actual): step %b/%b dir %b/%b ",
                            "enable %b/%b endstop %b/%b busy %b/%b fault %b/%b"},
                           want.step_pulse, seen.step_pulse, want.dir_level,
                           seen.dir_level, want.enable_level, seen.enable_level,
                           want.at_endstop, seen.at_endstop, want.busy_res,
                           seen.busy_res, want.timeout_fault, seen.timeout_fault);
            end
         end
      end
   end

   // watchdog: any transaction on any channel resets the count
   initial begin
      while (stuck_cycles < STUCK_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            stuck_cycles = 0;
         else
            stuck_cycles++;
      end
      $display("Mismatches found");
      $finish;
   end

   initial begin
      int random_base;
      int round_start;
      int round;
      int seek_len;
      logic [15:0] dwell;
      logic [15:0] backoff;
      logic [7:0] secs;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table, pins read as step dir enable endstop busy fault
      // idle ticks with the reset settings: driver disabled, switch sampled only
      plan_item(OP_TICK, 1'b0, 1'b0, 1'b1, 6'b001000);
      plan_item(OP_TICK, 1'b1, 1'b1, 1'b1, 6'b001100);
      // unused operation code acts as a plain switch sample
      plan_item(OP_UNUSED, 1'b1, 1'b1, 1'b1, 6'b001100);
      // single step off the endstop steps and enables the driver
      plan_item(OP_STEP, 1'b1, 1'b0, 1'b1, 6'b110000);
      // single step on the endstop does not step
      plan_item(OP_STEP, 1'b0, 1'b1, 1'b1, 6'b000100);
      // start while already on the endstop
      plan_item(OP_START, 1'b1, 1'b1, 1'b1, 6'b010110);
      // commands during a seek are dropped
      plan_item(OP_START, 1'b0, 1'b0, 1'b1, 6'b010010);
      plan_item(OP_STEP, 1'b0, 1'b1, 1'b1, 6'b010110);
      // first seek tick sees the switch, no back-off steps: idle, direction reversed
      plan_item(OP_TICK, 1'b0, 1'b1, 1'b1, 6'b000100);
      // active low switch, longest dwell, zero timeout: the seek runs out of time
      plan_csr(CSR_ACTIVE_LEVEL, 16'd0);
      plan_csr(CSR_DWELL_US, 16'hFFFF);
      plan_csr(CSR_BACKOFF_STEPS, 16'd1);
      plan_csr(CSR_TIMEOUT_SECONDS, 16'd0);
      plan_item(OP_START, 1'b0, 1'b1);
      repeat (16) plan_item(OP_TICK, 1'b1, 1'b1);
      plan_item(OP_TICK, 1'b0, 1'b0);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            if (i == 0 || plan[i-1].kind != ROW_CSR) settle_block();
            write_csr(plan[i].idx, plan[i].data);
            if (i == plan.size() - 1 || plan[i+1].kind != ROW_CSR) begin
               @(negedge clock);
               csr_valid <= 1'b0;
            end
         end else begin
            send_command(plan[i].op, plan[i].dir, plan[i].sw, plan[i].typed, plan[i].want);
         end
      end

      // longer run: a seek at the largest dwell that runs into a one second
      // timeout, then a short back-off
      apply_settings(1'b1, 16'hFFFF, 16'd8, 8'd1);
      send_command(OP_START, 1'($urandom_range(1)), ~cfg_active);
      while (mode != HOME_IDLE)
         send_command(OP_TICK, 1'($urandom_range(1)),
                      (mode == HOME_SEEK) ? ~cfg_active : 1'($urandom_range(1)));

      // random rounds, each under fresh settings; mostly full homing sequences
      random_base = items_sent;
      round = 0;
      while (items_sent - random_base < RANDOM_ITEMS) begin
         case ($urandom_range(4))
            0: dwell = 16'd0;
            1: dwell = 16'd1;
            2: dwell = 16'hFFFF;
            default: dwell = 16'($urandom_range(40000, 65535));
         endcase
         case ($urandom_range(3))
            0: backoff = 16'd0;
            1: backoff = 16'd1;
            default: backoff = 16'($urandom_range(2, 6));
         endcase
         case ($urandom_range(3))
            0: secs = 8'd0;
            1: secs = 8'hFF;
            default: secs = 8'($urandom_range(1, 2));
         endcase
         apply_settings(1'($urandom_range(1)), dwell, backoff, secs);
         // one round with no idling on either side, another with a long hold-off
         calm = (round == 1);
         if (round == 3) hold_req = 1'b1;
         round_start = items_sent;
         while (items_sent - round_start < ROUND_ITEMS) begin
            if ($urandom_range(99) < 75) begin
               send_command(OP_START, 1'($urandom_range(1)), 1'($urandom_range(1)));
               seek_len = $urandom_range(40);
               repeat (seek_len) begin
                  if ($urandom_range(19) == 0)
                     send_command($urandom_range(1) ? OP_START : OP_STEP,
                                  1'($urandom_range(1)), 1'($urandom_range(1)));
                  else
                     send_command(OP_TICK, 1'($urandom_range(1)),
                                  ($urandom_range(9) == 0) ? cfg_active : ~cfg_active);
               end
               send_command(OP_TICK, 1'($urandom_range(1)), cfg_active);
               repeat (int'(cfg_backoff) + $urandom_range(2))
                  send_command(OP_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)));
            end else begin
               repeat ($urandom_range(1, 4))
                  send_command(2'($urandom_range(3)), 1'($urandom_range(1)),
                               1'($urandom_range(1)));
            end
         end
         round++;
      end
      calm = 1'b0;

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_pins.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

FILE: files.f
sv/shs_pkg.sv
sv/shs_core.sv
sv/stepper_homing_sequencer.sv
tb/tb_stepper_homing_sequencer.sv
